### hdl/sha1_pkg.sv
package sha1_pkg;

    typedef logic [31:0] t_word;
    // Entry 0 holds H0 / a, entry 4 holds H4 / e.
    typedef logic [4:0][31:0] t_hash;

    // Byte intake and control toward the compression core.
    typedef struct packed {
        logic       push;   // shift one byte into the block
        logic       last;   // byte completes the 64-byte block, start rounds
        logic       init;   // reload the chaining hash with the initial value
        logic [7:0] data;
    } t_core_ctl;

    typedef struct packed {
        logic busy;         // rounds or fold in progress
    } t_core_sts;

    localparam t_hash HASH_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [3:0][31:0] ROUND_K = {
        32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
    };

    localparam int unsigned ROUNDS      = 80;
    localparam logic [6:0]  LAST_ROUND  = 7'(ROUNDS - 1);
    localparam logic [5:0]  LAST_FILL   = 6'd63;
    localparam logic [5:0]  LEN_FILL    = 6'd56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    // Round function groups, twenty rounds each.
    localparam logic [1:0] F_CHOOSE   = 2'd0;
    localparam logic [1:0] F_PARITY   = 2'd1;
    localparam logic [1:0] F_MAJORITY = 2'd2;
    localparam logic [1:0] F_PARITY2  = 2'd3;

    function automatic t_word round_f(input logic [1:0] grp, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        unique case (grp)
            F_CHOOSE:   f = (b & c) | (~b & d);
            F_MAJORITY: f = (b & c) | (b & d) | (c & d);
            F_PARITY,
            F_PARITY2:  f = b ^ c ^ d;
            default:    f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

### hdl/sha1_core.sv
module sha1_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha1_pkg::t_core_ctl   i_ctl,
    output sha1_pkg::t_core_sts   o_sts,
    output sha1_pkg::t_hash       o_hash
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_FIN  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [6:0]           r_round, n_round;
    sha1_pkg::t_hash      r_hash;
    sha1_pkg::t_word      r_a, r_b, r_c, r_d, r_e;
    sha1_pkg::t_word      r_w [16];

    logic [1:0]           grp;
    sha1_pkg::t_word      f_val;
    sha1_pkg::t_word      tmp;
    sha1_pkg::t_word      w_next;

    always_comb begin
        priority if (r_round < 7'd20) begin
            grp = sha1_pkg::F_CHOOSE;
        end else if (r_round < 7'd40) begin
            grp = sha1_pkg::F_PARITY;
        end else if (r_round < 7'd60) begin
            grp = sha1_pkg::F_MAJORITY;
        end else begin
            grp = sha1_pkg::F_PARITY2;
        end
    end

    // Window holds W[t..t+15]; the expansion runs ahead by sixteen words.
    assign w_next = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign f_val  = sha1_pkg::round_f(grp, r_b, r_c, r_d);
    assign tmp    = {r_a[26:0], r_a[31:27]} + f_val + r_e + r_w[0]
                    + sha1_pkg::ROUND_K[grp];

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        unique case (r_state)
            C_IDLE: begin
                if (i_ctl.push && i_ctl.last) begin
                    n_state = C_RUN;
                    n_round = '0;
                end
            end
            C_RUN: begin
                n_round = r_round + 7'd1;
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_state = C_FIN;
                end
            end
            C_FIN:   n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_hash  <= sha1_pkg::HASH_INIT;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            if (i_ctl.init) begin
                r_hash <= sha1_pkg::HASH_INIT;
            end else if (r_state == C_FIN) begin
                r_hash[0] <= r_hash[0] + r_a;
                r_hash[1] <= r_hash[1] + r_b;
                r_hash[2] <= r_hash[2] + r_c;
                r_hash[3] <= r_hash[3] + r_d;
                r_hash[4] <= r_hash[4] + r_e;
            end
        end
    end

    // Datapath: byte packing, schedule window, working variables.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], i_ctl.data};
        end else if (r_state == C_RUN) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= {w_next[30:0], w_next[31]};
        end
        if (r_state == C_IDLE && i_ctl.push && i_ctl.last) begin
            r_a <= r_hash[0];
            r_b <= r_hash[1];
            r_c <= r_hash[2];
            r_d <= r_hash[3];
            r_e <= r_hash[4];
        end else if (r_state == C_RUN) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_hash     = r_hash;

`ifndef SYNTHESIS
    ap_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> r_state == C_IDLE)
        else $error("byte pushed while rounds in progress");

    ap_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == C_RUN |-> r_round <= sha1_pkg::LAST_ROUND)
        else $error("round counter past last round");

    ap_fold_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_RUN && r_round == sha1_pkg::LAST_ROUND) |=> r_state == C_FIN)
        else $error("fold did not follow the last round");

    ap_init_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.init |-> r_state == C_IDLE)
        else $error("hash reload during compression");
`endif

endmodule

### hdl/sha1_message_digest_unit.sv
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_msg_byte, i_byte_present,
//                                                   i_end_of_message
// output    out        o_out_valid / i_out_ready    o_digest_word, o_word_index,
//                                                   o_last_word
//
// Intake: a data byte is taken on each handshake. The 64th byte of a block
//   starts the compression in sha1_core: 80 rounds through one shared round
//   adder, one round per cycle, then a fold step; o_in_ready stays low until
//   the fold is done, so no new byte is taken while a block is compressed.
// End of message: padding bytes are pushed one per cycle while the core is
//   idle (0x80, zeros, then the 8 length bytes), with one or two compressions,
//   after which the five digest words go out, one transaction each.
// Reset: i_rst_n, synchronous, active low; loads the initial chaining value
//   and clears the byte count and bit length.
// Stalls: a held o_out_valid keeps o_in_ready low; no new message starts
//   until the fifth word transaction completes.
module sha1_message_digest_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    // Sequencer states: take bytes, pad marker, zero fill, length, emit.
    localparam logic [2:0] ST_IN   = 3'd0;
    localparam logic [2:0] ST_MARK = 3'd1;
    localparam logic [2:0] ST_ZERO = 3'd2;
    localparam logic [2:0] ST_LEN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [2:0] LAST_IDX = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [5:0]           r_fill, n_fill;     // bytes held in current block
    logic [63:0]          r_bitlen, n_bitlen; // message length in bits
    logic [2:0]           r_widx, n_widx;     // digest word being sent

    sha1_pkg::t_core_ctl  ctl;
    sha1_pkg::t_core_sts  sts;
    sha1_pkg::t_hash      hash;

    logic                 in_ready;
    logic                 out_valid;

    sha1_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_hash  (hash)
    );

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_bitlen  = r_bitlen;
        n_widx    = r_widx;
        ctl       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (r_state)
            ST_IN: begin
                in_ready = !sts.busy;
                if (i_in_valid && in_ready) begin
                    if (i_byte_present) begin
                        ctl.push = 1'b1;
                        ctl.data = i_msg_byte;
                        ctl.last = (r_fill == sha1_pkg::LAST_FILL);
                        n_fill   = r_fill + 6'd1;
                        n_bitlen = r_bitlen + 64'd8;
                    end
                    if (i_end_of_message) begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (!sts.busy) begin
                    ctl.push = 1'b1;
                    ctl.data = sha1_pkg::PAD_MARK;
                    ctl.last = (r_fill == sha1_pkg::LAST_FILL);
                    n_fill   = r_fill + 6'd1;
                    n_state  = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (!sts.busy) begin
                    if (r_fill == sha1_pkg::LEN_FILL) begin
                        n_state = ST_LEN;
                    end else begin
                        ctl.push = 1'b1;
                        ctl.data = 8'h00;
                        ctl.last = (r_fill == sha1_pkg::LAST_FILL);
                        n_fill   = r_fill + 6'd1;
                    end
                end
            end
            ST_LEN: begin
                // Length goes out MSB first; shifting empties the counter.
                ctl.push = 1'b1;
                ctl.data = r_bitlen[63:56];
                ctl.last = (r_fill == sha1_pkg::LAST_FILL);
                n_fill   = r_fill + 6'd1;
                n_bitlen = {r_bitlen[55:0], 8'h00};
                if (r_fill == sha1_pkg::LAST_FILL) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                out_valid = !sts.busy;
                if (out_valid && i_out_ready) begin
                    if (r_widx == LAST_IDX) begin
                        ctl.init = 1'b1;
                        n_widx   = '0;
                        n_fill   = '0;
                        n_bitlen = '0;
                        n_state  = ST_IN;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: n_state = ST_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IN;
            r_fill   <= '0;
            r_bitlen <= '0;
            r_widx   <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            r_widx   <= n_widx;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = out_valid;
    assign o_digest_word = hash[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == LAST_IDX);

`ifndef SYNTHESIS
    ap_len_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LEN |-> r_fill >= sha1_pkg::LEN_FILL)
        else $error("length bytes outside block tail");

    ap_out_core_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!sts.busy && r_state == ST_OUT))
        else $error("digest shown while compression runs");

    ap_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_word)
        |=> (r_state == ST_IN && r_fill == '0 && r_bitlen == '0))
        else $error("message state not cleared after digest");

    ap_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= LAST_IDX)
        else $error("digest word index out of range");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

// SHA-1 byte-stream digest unit testbench.
//
// Byte transactions are queued up front by the stimulus block and pushed into
// the DUT by a clocked driver. The driver runs the digest prediction for each
// accepted byte transaction. A clocked monitor checks each digest word
// transaction against the oldest predicted word.
//
// Stimulus:
//   - directed: empty message, "abc" with an ignored item in the middle,
//     0x00/0xff bytes, end flag carried on an item of its own, single byte
//   - back-pressure: receiver holds off while short messages keep coming
//   - calm stretch with no idling on either side, covering the padding
//     corner lengths 55, 56, 63 and 64 bytes
//   - random messages, mostly short, a few spanning two or three blocks
module tb;

    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned IDLE_PCT     = 28;    // idle cycles per hundred, each side
    localparam int unsigned NOISE_PCT    = 6;     // chance of an ignored item before a byte
    localparam int unsigned TOTAL_ITEMS  = 430;   // byte and end transactions, noise excluded
    localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int unsigned TAIL_CYCLES  = 200;   // quiet time after the last digest word
    localparam int unsigned STALL_LIMIT  = 5000;  // cycles with no transaction at all

    // Initial chaining value and round constants, per FIPS 180.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;
    localparam logic [31:0] K_CHOOSE   = 32'h5a827999;
    localparam logic [31:0] K_PARITY   = 32'h6ed9eba1;
    localparam logic [31:0] K_MAJORITY = 32'h8f1bbcdc;
    localparam logic [31:0] K_PARITY2  = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;   // length field starts here

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eom;
        logic       drain_first;  // hold this item until all digests are back
    } t_msg_item;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    // DUT ports; every input is known from time zero.
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic [7:0]  i_msg_byte       = 8'h00;
    logic        i_byte_present   = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_message_digest_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_msg_byte       (i_msg_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and expectation stores.
    t_msg_item    pending_q[$];
    t_digest_word digest_q[$];
    t_msg_item    cur_item;
    logic         drain_next  = 1'b0;
    int unsigned  real_items  = 0;
    int unsigned  eom_queued  = 0;

    // Phase markers, in message counts.
    int unsigned  pressure_msg = 0;
    int unsigned  calm_lo      = 0;
    int unsigned  calm_hi      = 0;

    // Progress counters; all but fail_count are NBA-updated so other processes see stable values.
    int unsigned  msgs_sent    = 0;
    int unsigned  bytes_sent   = 0;
    int unsigned  ignored_sent = 0;
    int unsigned  words_due    = 0;
    int unsigned  words_done   = 0;
    int unsigned  fail_count   = 0;

    wire calm = (msgs_sent >= calm_lo) && (msgs_sent < calm_hi);

    // ------------------------------------------------------------------
    // Digest prediction: chaining hash, partial block, running bit length.
    // ------------------------------------------------------------------
    logic [31:0] chain_h [5];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void sha_restart();
        chain_h[0] = IV0;
        chain_h[1] = IV1;
        chain_h[2] = IV2;
        chain_h[3] = IV3;
        chain_h[4] = IV4;
        blk_fill   = '0;
        msg_bits   = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        for (int t = 0; t < 16; t++) begin
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = rol32(w[(t+13) & 15] ^ w[(t+8) & 15] ^ w[(t+2) & 15] ^ w[t & 15], 1);
                w[t & 15] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PARITY;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = K_PARITY2;
            end
            sum = rol32(a, 5) + f + e + wt + k;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = sum;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void sha_absorb(input logic [7:0] v);
        blk_bytes[blk_fill] = v;
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0) sha_compress();
    endfunction

    // One accepted byte transaction; on end of message, pad, append the
    // length and queue the five expected digest words.
    function automatic void predict_digest(input t_msg_item it);
        logic [63:0] len;
        if (it.present) begin
            sha_absorb(it.data);
            msg_bits += 64'd8;
        end
        if (it.eom) begin
            len = msg_bits;
            sha_absorb(PAD_BYTE);
            while (blk_fill != LEN_OFFSET) sha_absorb(8'h00);
            for (int i = 0; i < 8; i++) sha_absorb(len[63 - 8*i -: 8]);
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                digest_q.push_back('{word: chain_h[i], idx: 3'(i),
                                     last: (i == DIGEST_WORDS - 1)});
            end
            sha_restart();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------
    function automatic void queue_item(input logic [7:0] data, input logic present,
                                       input logic eom);
        pending_q.push_back('{data: data, present: present, eom: eom,
                              drain_first: drain_next});
        drain_next = 1'b0;
        if (present || eom) real_items++;
        if (eom) eom_queued++;
    endfunction

    // Random bytes; the end flag rides on the last byte or, sometimes, on an
    // item of its own. Ignored items are sprinkled in as noise.
    function automatic void queue_message(input int unsigned len);
        bit split_end;
        split_end = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int unsigned n = 0; n < len; n++) begin
            if ($urandom_range(0, 99) < NOISE_PCT) queue_item(8'($urandom), 1'b0, 1'b0);
            queue_item(8'($urandom), 1'b1, !split_end && (n == len - 1));
        end
        if (split_end) queue_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    initial begin
        int unsigned pick;

        sha_restart();

        // Directed: empty message, "abc" around an ignored item, byte
        // extremes, end-only item after data (its byte must be ignored).
        queue_item(8'ha5, 1'b0, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'h12, 1'b1, 1'b0);
        queue_item(8'h34, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);

        // Back-pressure: receiver stalls once the first of these is in.
        drain_next   = 1'b1;
        pressure_msg = eom_queued;
        repeat (16) queue_message($urandom_range(0, 3));

        // Calm stretch after a full drain: padding corner lengths.
        drain_next = 1'b1;
        calm_lo    = eom_queued;
        queue_message(55);
        queue_message($urandom_range(0, 6));
        queue_message(56);
        queue_message(63);
        queue_message($urandom_range(0, 6));
        queue_message(64);
        calm_hi    = eom_queued;

        // Random part.
        while (real_items < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      queue_message($urandom_range(0, 10));
            else if (pick < 96) queue_message($urandom_range(11, 70));
            else                queue_message($urandom_range(100, 130));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wind down on falling edges, clear of the clocked processes.
        while (pending_q.size() != 0 || i_in_valid) @(negedge i_clk);
        while (words_done != words_due) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (digest_q.size() != 0) begin
            $display("%0t: %0d digest words never arrived", $time, digest_q.size());
            fail_count++;
        end
        $display("covered %0d messages, %0d data bytes, %0d ignored items, incl. lengths 55, 56, 63, 64",
                 msgs_sent, bytes_sent, ignored_sent);
        $display("checked %0d digest words, %0d failures", words_done, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver: one byte transaction per handshake. Valid drops only
    // after a transaction completes; drain-marked items wait for every
    // outstanding digest word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        logic        took_eom;
        int unsigned due_now;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took_eom = 1'b0;
            if (i_in_valid && o_in_ready) begin
                predict_digest(cur_item);
                took_eom = cur_item.eom;
                if (cur_item.eom) begin
                    msgs_sent <= msgs_sent + 1;
                    words_due <= words_due + DIGEST_WORDS;
                end
                if (cur_item.present) bytes_sent <= bytes_sent + 1;
                if (!cur_item.present && !cur_item.eom) ignored_sent <= ignored_sent + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                due_now = words_due + (took_eom ? DIGEST_WORDS : 0);
                if (pending_q.size() != 0
                    && !(pending_q[0].drain_first && due_now != words_done)
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_item = pending_q.pop_front();
                    i_in_valid       <= 1'b1;
                    i_msg_byte       <= cur_item.data;
                    i_byte_present   <= cur_item.present;
                    i_end_of_message <= cur_item.eom;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output ready: random idling, one long hold-off during the
    // back-pressure phase so the DUT backs up into its input.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && msgs_sent > pressure_msg) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each digest word transaction against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : digest_monitor
        t_digest_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word, expected none, actual %h idx %0d",
                         $time, o_digest_word, o_word_index);
                fail_count++;
            end else begin
                want = digest_q.pop_front();
                check_field("digest_word", want.word, o_digest_word);
                check_field("word_index", 32'(want.idx), 32'(o_word_index));
                check_field("last_word", 32'(want.last), 32'(o_last_word));
                words_done <= words_done + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without a transaction on either channel.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d digest words outstanding",
                     $time, quiet_cycles, words_due - words_done);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### files.f
hdl/sha1_pkg.sv
hdl/sha1_core.sv
hdl/sha1_message_digest_unit.sv
dv/tb.sv
